// ===== src/mfmtd_pkg.sv =====
package mfmtd_pkg;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int LIMIT_W     = 24;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 160;

  localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST  = 24'd819200;
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST  = 24'd1966080;
  localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST = 24'd655360;

  localparam logic        [12:0] MIDPOINT   = 13'd2047;
  localparam logic signed [16:0] HALF_TURN  = 17'sd32768;
  localparam logic        [32:0] OFFSET     = 33'd32767;
  localparam logic        [15:0] FULL_COUNT = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ANGLE_LIMIT  = 2'd0,
    CFG_SPEED_LIMIT  = 2'd1,
    CFG_TORQUE_LIMIT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] angle_limit;
    logic [LIMIT_W-1:0] speed_limit;
    logic [LIMIT_W-1:0] torque_limit;
  } limits_t;

  // One decoded frame after the turn update, waiting for scaling.
  typedef struct packed {
    logic [15:0] turn_count;
    logic [32:0] total_position;
    logic [11:0] raw_speed;
    logic [11:0] raw_torque;
    logic [7:0]  driver_temp;
    logic [7:0]  rotor_temp;
  } front_item_t;

endpackage

// ===== src/mfmtd_front.sv =====
module mfmtd_front
  import mfmtd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 q_full,
  output logic                 push,
  output front_item_t          push_item
);

  logic [15:0]        position;
  logic [15:0]        prev_position_r;
  logic [15:0]        turns_r;
  logic [15:0]        turns_nxt;
  logic signed [16:0] delta;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  assign position = {in_tdata[7:0], in_tdata[15:8]};
  assign delta    = $signed({1'b0, position}) - $signed({1'b0, prev_position_r});

  // A jump of exactly half a turn either way leaves the count alone.
  always_comb begin
    priority if (delta < -HALF_TURN) begin
      turns_nxt = turns_r + 16'd1;
    end else if (delta > HALF_TURN) begin
      turns_nxt = turns_r - 16'd1;
    end else begin
      turns_nxt = turns_r;
    end
  end

  always_comb begin
    push_item.turn_count     = turns_nxt;
    push_item.total_position = {turns_nxt[15], turns_nxt, position} - OFFSET;
    push_item.raw_speed      = {in_tdata[23:16], in_tdata[31:28]};
    push_item.raw_torque     = {in_tdata[27:24], in_tdata[39:32]};
    push_item.driver_temp    = in_tdata[47:40];
    push_item.rotor_temp     = in_tdata[55:48];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_position_r <= '0;
      turns_r         <= '0;
    end else if (push) begin
      prev_position_r <= position;
      turns_r         <= turns_nxt;
    end
  end

endmodule

// ===== src/mfmtd_queue.sv =====
module mfmtd_queue
  import mfmtd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  front_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        pop_valid,
  output front_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  front_item_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == DEPTH_CNT);
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("item pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("item popped from an empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

// ===== src/mfmtd_back.sv =====
module mfmtd_back
  import mfmtd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  front_item_t           q_item,
  output logic                  pop,
  input  limits_t               limits,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [17:0] ONE_COUNT   = {2'b00, FULL_COUNT};
  localparam logic [17:0] TWO_COUNT   = 18'(2 * FULL_COUNT);
  localparam logic [17:0] THREE_COUNT = 18'(3 * FULL_COUNT);

  logic advance;
  logic [5:0] valid_r;

  // Fields that ride along unchanged from stage to stage.
  front_item_t        pass1_r, pass2_r, pass3_r, pass4_r, pass5_r, pass6_r;

  logic [5:1]         neg_r;
  logic [31:0]        mag1_r;
  logic signed [12:0] dspeed1_r;
  logic signed [12:0] dtorque1_r;

  logic [55:0]        prod_a2_r;
  logic signed [37:0] prod_s2_r;
  logic signed [37:0] prod_t2_r;

  logic [56:0]        dividend;
  logic [40:0]        q_est3_r;
  logic [17:0]        x_lo3_r;
  logic [24:0]        speed3_r, speed4_r, speed5_r, speed6_r;
  logic [24:0]        torque3_r, torque4_r, torque5_r, torque6_r;

  logic [40:0]        q_est4_r;
  logic [17:0]        rem4_r;
  logic [40:0]        quot5_r;
  logic [41:0]        angle6_r;

  logic [32:0]        total_neg;
  logic [1:0]         corr;

  assign advance = !valid_r[5] || out_tready;
  assign pop     = q_valid && advance;

  assign total_neg = '0 - q_item.total_position;
  assign dividend  = {prod_a2_r, 1'b0};

  // The estimate undershoots the quotient by at most three.
  always_comb begin
    priority if (rem4_r >= THREE_COUNT) begin
      corr = 2'd3;
    end else if (rem4_r >= TWO_COUNT) begin
      corr = 2'd2;
    end else if (rem4_r >= ONE_COUNT) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (advance) begin
      valid_r <= {valid_r[4:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // Stage 1: magnitude of the position and offsets from the midpoint.
      pass1_r    <= q_item;
      neg_r[1]   <= q_item.total_position[32];
      mag1_r     <= q_item.total_position[32] ? total_neg[31:0]
                                              : q_item.total_position[31:0];
      dspeed1_r  <= $signed({1'b0, q_item.raw_speed}) - $signed(MIDPOINT);
      dtorque1_r <= $signed({1'b0, q_item.raw_torque}) - $signed(MIDPOINT);

      // Stage 2: products with the full-scale registers.
      pass2_r   <= pass1_r;
      neg_r[2]  <= neg_r[1];
      prod_a2_r <= 56'(mag1_r) * 56'(limits.angle_limit);
      prod_s2_r <= dspeed1_r * $signed({1'b0, limits.speed_limit});
      prod_t2_r <= dtorque1_r * $signed({1'b0, limits.torque_limit});

      // Stage 3: quotient estimate by 65535 as a sum of shifted copies.
      pass3_r   <= pass2_r;
      neg_r[3]  <= neg_r[2];
      q_est3_r  <= dividend[56:16] + 41'(dividend[56:32]) + 41'(dividend[56:48]);
      x_lo3_r   <= dividend[17:0];
      speed3_r  <= prod_s2_r[35:11];
      torque3_r <= prod_t2_r[35:11];

      // Stage 4: remainder of the estimate, only its low bits matter.
      pass4_r   <= pass3_r;
      neg_r[4]  <= neg_r[3];
      q_est4_r  <= q_est3_r;
      rem4_r    <= x_lo3_r - {q_est3_r[1:0], 16'h0000} + q_est3_r[17:0];
      speed4_r  <= speed3_r;
      torque4_r <= torque3_r;

      // Stage 5: corrected quotient.
      pass5_r   <= pass4_r;
      neg_r[5]  <= neg_r[4];
      quot5_r   <= q_est4_r + 41'(corr);
      speed5_r  <= speed4_r;
      torque5_r <= torque4_r;

      // Stage 6: restore the sign, truncating toward zero.
      pass6_r   <= pass5_r;
      angle6_r  <= neg_r[5] ? ('0 - {1'b0, quot5_r}) : {1'b0, quot5_r};
      speed6_r  <= speed5_r;
      torque6_r <= torque5_r;
    end
  end

  assign out_tvalid = valid_r[5];
  assign out_tdata  = {3'b000, pass6_r.rotor_temp, pass6_r.driver_temp, torque6_r, speed6_r,
                       angle6_r, pass6_r.total_position, pass6_r.turn_count};

endmodule

// ===== src/motor_feedback_multiturn_decoder.sv =====
// Motor feedback multi-turn decoder. Each input item is one seven-byte
// feedback frame; each produces exactly one result item with the turn count,
// the multi-turn position, the scaled angle, speed and torque, and the two
// temperature bytes. The block takes one item every clock cycle while the
// queue is not full. The turn update is done at the front as the item is
// accepted, and a six-stage back pipeline (one multiplier rank, then the
// divide by 65535 as a sum of shifts with a small correction) does the
// scaling. A queue of QUEUE_DEPTH_P items between them lets the input keep
// flowing while results wait. Limits must be written by the user through the
// cfg_ port only while the block is idle; the block does not enforce this.
// The port is always ready and writes to an unused index are dropped.
module motor_feedback_multiturn_decoder
  import mfmtd_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // position_high, position_low, speed_high, speed_torque_mixed, torque_low,
  // driver_temp_in, rotor_temp_in
  input  logic [IN_DATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // turn_count, total_position, angle, speed, torque, driver_temp,
  // rotor_temp, zero pad
  output logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data
);

  limits_t     limits_r;
  logic        q_full;
  logic        push;
  front_item_t push_item;
  logic        pop;
  logic        q_valid;
  front_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.angle_limit  <= ANGLE_LIMIT_RST;
      limits_r.speed_limit  <= SPEED_LIMIT_RST;
      limits_r.torque_limit <= TORQUE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANGLE_LIMIT:  limits_r.angle_limit  <= cfg_data;
        CFG_SPEED_LIMIT:  limits_r.speed_limit  <= cfg_data;
        CFG_TORQUE_LIMIT: limits_r.torque_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mfmtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  mfmtd_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  mfmtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .limits     (limits_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
